@@ sv/prt_pkg.sv @@
// ============================================================================
// prt_pkg
// Shared types and constants for the pin reservation table.
// ============================================================================
package prt_pkg;

    localparam int PIN_COUNT  = 64;
    localparam int USER_LIMIT = 127;

    localparam int PIN_W = 6;
    localparam int CNT_W = 7;
    localparam int TOT_W = 13;
    localparam int MEM_DEPTH = 2 ** PIN_W;

    localparam logic [PIN_W-1:0] PIN_LAST  = PIN_W'(PIN_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(USER_LIMIT - 2);

    // opcodes
    localparam logic [2:0] OP_START_PIN  = 3'd0;
    localparam logic [2:0] OP_STOP_PIN   = 3'd1;
    localparam logic [2:0] OP_START_MASK = 3'd2;
    localparam logic [2:0] OP_STOP_MASK  = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BUSY      = 2'd1;
    localparam logic [1:0] ST_NO_USERS  = 2'd2;
    localparam logic [1:0] ST_CANT_LOCK = 2'd3;

    typedef struct packed {
        logic             locked;
        logic [CNT_W-1:0] count;
    } t_rec;

    // update unit verdict
    typedef struct packed {
        logic start_ok;
        logic stop_ok;
    } t_verdict;

endpackage

@@ sv/prt_rec_mem.sv @@
// ============================================================================
// prt_rec_mem
// Per-pin record store, one write and one registered read port. Valid bits
// make never-written records read back as zero after reset.
// ============================================================================
module prt_rec_mem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [prt_pkg::PIN_W-1:0] i_rd_addr,
    output prt_pkg::t_rec        o_rd_data,
    input  logic                 i_wr_en,
    input  logic [prt_pkg::PIN_W-1:0] i_wr_addr,
    input  prt_pkg::t_rec        i_wr_data
);
    import prt_pkg::*;

    t_rec                 r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    t_rec                 r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ sv/prt_upd_unit.sv @@
// ============================================================================
// prt_upd_unit
// Shared compare/update unit: judges one pin record for start and stop and
// forms the updated records.
// ============================================================================
module prt_upd_unit (
    input  prt_pkg::t_rec     i_rec,
    input  logic              i_lock,
    output prt_pkg::t_verdict o_verdict,
    output prt_pkg::t_rec     o_start_rec,
    output prt_pkg::t_rec     o_stop_rec
);
    import prt_pkg::*;

    logic in_use;

    assign in_use = (i_rec.count != '0);

    assign o_verdict.start_ok = !i_rec.locked && !(i_lock && in_use)
                                && (i_rec.count < CNT_LIMIT);
    assign o_verdict.stop_ok  = in_use;

    assign o_start_rec.count  = i_rec.count + CNT_W'(1);
    assign o_start_rec.locked = i_rec.locked | i_lock;

    assign o_stop_rec.count   = i_rec.count - CNT_W'(1);
    assign o_stop_rec.locked  = 1'b0;

endmodule

@@ sv/pin_reservation_table_core.sv @@
// ============================================================================
// pin_reservation_table_core
// Reservation table for 64 I/O pins: per-pin user count and lock flag plus a
// global user count, walked one record per cycle by a small sequencer.
// ============================================================================
// Sequence: a query reads its pin once; single start/stop walks that pin's record;
// mask stop walks every pin; mask start walks every pin once when refused and twice
// when granted (check pass, then apply pass).
// Flow: one transaction at a time; the next one is taken once the result loads,
// which waits while a previous response is stalled. The walk reads one pin record per cycle.
// Reset: synchronous active low; all pins free and unlocked, count zero.
module pin_reservation_table_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_opcode,
    input  logic [prt_pkg::PIN_W-1:0] i_pin_index,
    input  logic                      i_lock_request,
    input  logic [63:0]               i_pin_mask,
    // response channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic                      o_pin_active,
    output logic [prt_pkg::TOT_W-1:0] o_total_users,
    output logic                      o_subsystem_on
);
    import prt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,  // stream records: read idx, process prev
        S_FINAL = 5'b00100,  // read addressed pin for pin_active
        S_RESP  = 5'b01000,  // load response register
        S_SPARE = 5'b10000   // never entered
    } t_state;

    t_state r_state, n_state;

    // latched transaction
    logic [2:0]       r_op, n_op;
    logic [PIN_W-1:0] r_pin, n_pin;
    logic             r_pin_ok, n_pin_ok;
    logic             r_lock, n_lock;
    logic [63:0]      r_mask, n_mask;

    // walk control
    logic [PIN_W-1:0] r_idx, n_idx;
    logic [PIN_W-1:0] r_end, n_end;
    logic             r_issue, n_issue;
    logic             r_prev_vld, n_prev_vld;
    logic [PIN_W-1:0] r_prev_idx, n_prev_idx;
    logic             r_apply, n_apply;   // mask start: second pass
    logic             r_fail, n_fail;     // mask start: some pin refused
    logic [1:0]       r_status, n_status;

    logic [TOT_W-1:0] r_gusers, n_gusers;

    // response register
    logic             r_out_vld, n_out_vld;
    logic [1:0]       r_out_status, n_out_status;
    logic             r_out_active, n_out_active;
    logic [TOT_W-1:0] r_out_total, n_out_total;

    // memory / unit hookup
    logic             rd_en;
    logic [PIN_W-1:0] rd_addr;
    t_rec             rd_data;
    logic             wr_en;
    t_rec             wr_data;
    t_verdict         verdict;
    t_rec             start_rec;
    t_rec             stop_rec;

    logic             mask_op;
    logic             sel;
    logic             proc;
    logic             pin_ok_in;

    prt_rec_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_prev_idx),
        .i_wr_data (wr_data)
    );

    prt_upd_unit u_upd (
        .i_rec       (rd_data),
        .i_lock      (r_lock),
        .o_verdict   (verdict),
        .o_start_rec (start_rec),
        .o_stop_rec  (stop_rec)
    );

    assign o_in_ready = (r_state == S_IDLE);

    assign mask_op   = (r_op == OP_START_MASK) || (r_op == OP_STOP_MASK);
    assign sel       = mask_op ? r_mask[r_prev_idx] : 1'b1;
    assign proc      = (r_state == S_WALK) && r_prev_vld && sel;
    assign pin_ok_in = ({1'b0, i_pin_index} < (PIN_W + 1)'(PIN_COUNT));

    assign rd_en   = ((r_state == S_WALK) && r_issue) || (r_state == S_FINAL);
    assign rd_addr = (r_state == S_FINAL) ? r_pin : r_idx;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_pin        = r_pin;
        n_pin_ok     = r_pin_ok;
        n_lock       = r_lock;
        n_mask       = r_mask;
        n_idx        = r_idx;
        n_end        = r_end;
        n_issue      = r_issue;
        n_prev_vld   = 1'b0;
        n_prev_idx   = r_idx;
        n_apply      = r_apply;
        n_fail       = r_fail;
        n_status     = r_status;
        n_gusers     = r_gusers;
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_active = r_out_active;
        n_out_total  = r_out_total;
        wr_en        = 1'b0;
        wr_data      = start_rec;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        // per-record work, one record per cycle
        if (proc) begin
            case (r_op)
                OP_START_PIN: begin
                    if (verdict.start_ok) begin
                        wr_en    = 1'b1;
                        n_gusers = r_gusers + TOT_W'(1);
                    end else begin
                        n_status = ST_BUSY;
                    end
                end
                OP_STOP_PIN: begin
                    wr_data = stop_rec;
                    if (verdict.stop_ok) begin
                        wr_en    = 1'b1;
                        n_gusers = r_gusers - TOT_W'(1);
                    end else begin
                        n_status = ST_NO_USERS;
                    end
                end
                OP_START_MASK: begin
                    if (r_apply) begin
                        wr_en    = 1'b1;
                        n_gusers = r_gusers + TOT_W'(1);
                    end else if (!verdict.start_ok) begin
                        n_fail = 1'b1;
                    end
                end
                OP_STOP_MASK: begin
                    wr_data = stop_rec;
                    if (verdict.stop_ok) begin
                        wr_en    = 1'b1;
                        n_gusers = r_gusers - TOT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_pin    = i_pin_index;
                    n_pin_ok = pin_ok_in;
                    n_lock   = i_lock_request;
                    n_mask   = i_pin_mask;
                    n_status = ST_OK;
                    n_apply  = 1'b0;
                    n_fail   = 1'b0;
                    n_issue  = 1'b1;
                    n_idx    = '0;
                    n_end    = PIN_LAST;
                    case (i_opcode)
                        OP_START_PIN, OP_STOP_PIN: begin
                            n_idx = i_pin_index;
                            n_end = i_pin_index;
                            if (pin_ok_in) begin
                                n_state = S_WALK;
                            end else begin
                                n_state  = S_FINAL;
                                n_status = (i_opcode == OP_START_PIN) ? ST_BUSY
                                                                      : ST_NO_USERS;
                            end
                        end
                        OP_START_MASK, OP_STOP_MASK: begin
                            n_state = S_WALK;
                        end
                        default: begin
                            n_state = S_FINAL;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_issue) begin
                    n_prev_vld = 1'b1;
                    if (r_idx == r_end) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + PIN_W'(1);
                    end
                end else if (!r_prev_vld) begin
                    // pass complete, last write already done
                    if ((r_op == OP_START_MASK) && !r_apply && !r_fail) begin
                        n_apply = 1'b1;
                        n_issue = 1'b1;
                        n_idx   = '0;
                    end else begin
                        if ((r_op == OP_START_MASK) && r_fail) begin
                            n_status = ST_CANT_LOCK;
                        end
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_status;
                    n_out_active = r_pin_ok && (rd_data.count != '0);
                    n_out_total  = r_gusers;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= 1'b0;
            r_prev_vld <= 1'b0;
            r_apply    <= 1'b0;
            r_fail     <= 1'b0;
            r_gusers   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_prev_vld <= n_prev_vld;
            r_apply    <= n_apply;
            r_fail     <= n_fail;
            r_gusers   <= n_gusers;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_pin        <= n_pin;
        r_pin_ok     <= n_pin_ok;
        r_lock       <= n_lock;
        r_mask       <= n_mask;
        r_idx        <= n_idx;
        r_end        <= n_end;
        r_prev_idx   <= n_prev_idx;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_active <= n_out_active;
        r_out_total  <= n_out_total;
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out_status;
    assign o_pin_active   = r_out_active;
    assign o_total_users  = r_out_total;
    assign o_subsystem_on = (r_out_total != '0);

endmodule

@@ sv/prt_checker.sv @@
// ============================================================================
// prt_checker
// Port-level checks for the pin reservation table, bound to the top level.
// ============================================================================
module prt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [1:0]                o_status,
    input logic                      o_pin_active,
    input logic [prt_pkg::TOT_W-1:0] o_total_users,
    input logic                      o_subsystem_on
);
    import prt_pkg::*;

    // response holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_total_users))
        else $error("response changed while stalled");

    // one transaction at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    a_on_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_subsystem_on == (o_total_users != '0)))
        else $error("subsystem_on disagrees with total users");

    a_active_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pin_active |-> o_total_users != '0)
        else $error("active pin with zero total users");

    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_total_users <= TOT_W'(PIN_COUNT * (USER_LIMIT - 2)))
        else $error("total users beyond capacity");

endmodule

bind pin_reservation_table_core prt_checker u_prt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_pin_active   (o_pin_active),
    .o_total_users  (o_total_users),
    .o_subsystem_on (o_subsystem_on)
);
